FILE: rtl/pftt_pkg.sv
package pftt_pkg;

   // field widths
   localparam int IDX_W  = 12;
   localparam int STEP_W = 32;
   localparam int POS_W  = 32;
   localparam int RAD_W  = 31;
   localparam int SUM_W  = 48;
   localparam int CNT_W  = 32;

   // number of distinct particle indexes the index field can carry
   localparam int IDX_SPACE = 2 ** IDX_W;

   // saturation limits
   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // per-item data that rides along the contact pipeline
   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [STEP_W-1:0] step;
      logic              last;
   } meta_type;

   // classified item handed from the front to the back
   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [STEP_W-1:0] step;
      logic              contact;
   } job_type;

   // one particle table entry
   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [STEP_W-1:0] last_sep;
      logic [CNT_W-1:0]  count;
      logic              flag;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{sum: '0, last_sep: '0, count: '0, flag: 1'b1};

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   // absolute difference of two signed coordinates, always below 2^32
   function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
      logic [POS_W:0] d;
      logic [POS_W:0] nd;
      d  = {a[POS_W-1], a} - {b[POS_W-1], b};
      nd = '0 - d;
      return d[POS_W] ? nd[POS_W-1:0] : d[POS_W-1:0];
   endfunction

endpackage

FILE: rtl/pftt_front.sv
module pftt_front #(
   parameter int PARTICLES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pftt_pkg::STEP_W-1:0]         start_step,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [pftt_pkg::IDX_W-1:0]          in_particle_index,
   input  logic                                in_in_group,
   input  logic [pftt_pkg::STEP_W-1:0]         in_step,
   input  logic signed [pftt_pkg::POS_W-1:0]   in_own_x,
   input  logic signed [pftt_pkg::POS_W-1:0]   in_own_y,
   input  logic signed [pftt_pkg::POS_W-1:0]   in_own_z,
   input  logic [pftt_pkg::RAD_W-1:0]          in_own_radius,
   input  logic signed [pftt_pkg::POS_W-1:0]   in_other_x,
   input  logic signed [pftt_pkg::POS_W-1:0]   in_other_y,
   input  logic signed [pftt_pkg::POS_W-1:0]   in_other_z,
   input  logic [pftt_pkg::RAD_W-1:0]          in_other_radius,
   input  logic                                in_last_neighbor,
   output logic                                job_push,
   output pftt_pkg::job_type                   job,
   input  logic                                job_full
);

   localparam int PW = pftt_pkg::POS_W;
   localparam int PRODW = 2 * PW;
   localparam int SUMW = PRODW + 2;

   logic                  advance;
   logic                  in_range;
   logic                  active;
   logic                  pair_contact;
   logic                  contact_any;

   logic                  v1_ff, v2_ff, v3_ff;
   pftt_pkg::meta_type    meta1_ff, meta2_ff, meta3_ff;
   logic [PW-1:0]         dx1_ff, dy1_ff, dz1_ff, rs1_ff;
   logic [PRODW-1:0]      px2_ff, py2_ff, pz2_ff, prs2_ff;
   logic [SUMW-1:0]       dist3_ff;
   logic [PRODW-1:0]      rsq3_ff;
   logic                  seen_ff;
   logic                  seen_in;

   // pipeline holds while a last pair waits for room in the queue
   assign advance  = !(v3_ff && meta3_ff.last && job_full);
   assign in_ready = advance;

   // classify: only tracked, started, in-range items enter the pipeline
   assign in_range = (32'(in_particle_index) < 32'(PARTICLES));
   assign active   = in_valid && in_in_group && (in_step >= start_step) && in_range;

   // last stage: exact contact test and or-accumulation over pairs
   assign pair_contact = (dist3_ff <= SUMW'(rsq3_ff));
   assign contact_any  = seen_ff || pair_contact;

   always_comb begin
      seen_in = seen_ff;
      if (v3_ff) begin
         seen_in = meta3_ff.last ? 1'b0 : contact_any;
      end
   end

   // job for the back end on each last pair
   assign job_push    = v3_ff && meta3_ff.last && !job_full;
   assign job.idx     = meta3_ff.idx;
   assign job.step    = meta3_ff.step;
   assign job.contact = contact_any;

   // valid bits and contact accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         seen_ff <= 1'b0;
      end else if (advance) begin
         v1_ff   <= active;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         seen_ff <= seen_in;
      end
   end

   // stage 1: coordinate differences and radius sum
   always_ff @(posedge clock) begin
      if (advance) begin
         meta1_ff.idx  <= in_particle_index;
         meta1_ff.step <= in_step;
         meta1_ff.last <= in_last_neighbor;
         dx1_ff <= pftt_pkg::abs_diff(in_own_x, in_other_x);
         dy1_ff <= pftt_pkg::abs_diff(in_own_y, in_other_y);
         dz1_ff <= pftt_pkg::abs_diff(in_own_z, in_other_z);
         rs1_ff <= PW'(in_own_radius) + PW'(in_other_radius);
      end
   end

   // stage 2: squares
   always_ff @(posedge clock) begin
      if (advance) begin
         meta2_ff <= meta1_ff;
         px2_ff   <= dx1_ff * dx1_ff;
         py2_ff   <= dy1_ff * dy1_ff;
         pz2_ff   <= dz1_ff * dz1_ff;
         prs2_ff  <= rs1_ff * rs1_ff;
      end
   end

   // stage 3: squared distance
   always_ff @(posedge clock) begin
      if (advance) begin
         meta3_ff <= meta2_ff;
         dist3_ff <= SUMW'(px2_ff) + SUMW'(py2_ff) + SUMW'(pz2_ff);
         rsq3_ff  <= prs2_ff;
      end
   end

endmodule

FILE: rtl/pftt_fifo.sv
module pftt_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  pftt_pkg::job_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output pftt_pkg::job_type rd_data,
   output logic              empty
);

   localparam int DEPTH = 4;
   localparam int PW = $clog2(DEPTH);

   pftt_pkg::job_type slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     rd_ptr_ff;
   logic [PW:0]       count_ff;
   logic              do_wr;
   logic              do_rd;

   assign full    = (count_ff == (PW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + (PW+1)'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - (PW+1)'(1);
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/pftt_back.sv
module pftt_back #(
   parameter int PARTICLES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_empty,
   input  pftt_pkg::job_type             job_head,
   output logic                          job_pop,
   output logic                          clearing,
   output logic                          rsp_valid,
   input  logic                          rsp_take,
   output logic [pftt_pkg::IDX_W-1:0]    rsp_out_particle,
   output logic [pftt_pkg::SUM_W-1:0]    rsp_free_time_total,
   output logic [pftt_pkg::CNT_W-1:0]    rsp_collisions,
   output logic                          rsp_touching
);

   localparam int DEPTH = (PARTICLES < pftt_pkg::IDX_SPACE) ? PARTICLES : pftt_pkg::IDX_SPACE;
   localparam int AW = $clog2(DEPTH);
   localparam int SW = pftt_pkg::SUM_W;

   pftt_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clr_ptr_ff;
   pftt_pkg::job_type   job_ff;
   pftt_pkg::entry_type rd_ff;
   pftt_pkg::entry_type upd;
   pftt_pkg::entry_type table_ff [DEPTH];

   logic                out_free;
   logic                clr_done;
   logic                mem_we;
   logic [AW-1:0]       mem_addr;
   pftt_pkg::entry_type mem_wdata;
   logic                load_out;

   logic                out_valid_ff;
   logic [pftt_pkg::STEP_W-1:0] add;
   logic [SW:0]         sum_wide;

   assign out_free = !out_valid_ff || rsp_take;
   assign clr_done = (clr_ptr_ff == AW'(DEPTH - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pftt_pkg::ST_CLEAR: begin
            if (clr_done) state_in = pftt_pkg::ST_IDLE;
         end
         pftt_pkg::ST_IDLE: begin
            if (!job_empty && out_free) state_in = pftt_pkg::ST_UPDATE;
         end
         pftt_pkg::ST_UPDATE: begin
            state_in = pftt_pkg::ST_IDLE;
         end
         default: state_in = pftt_pkg::ST_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      job_pop   = 1'b0;
      clearing  = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = job_ff.idx[AW-1:0];
      mem_wdata = upd;
      load_out  = 1'b0;
      case (state_ff)
         pftt_pkg::ST_CLEAR: begin
            clearing  = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = clr_ptr_ff;
            mem_wdata = pftt_pkg::ENTRY_RESET;
         end
         pftt_pkg::ST_IDLE: begin
            job_pop = !job_empty && out_free;
         end
         pftt_pkg::ST_UPDATE: begin
            mem_we   = 1'b1;
            load_out = 1'b1;
         end
         default: begin
            clearing = 1'b1;
         end
      endcase
   end

   // table entry update from the read entry and the job
   always_comb begin
      add      = (job_ff.step >= rd_ff.last_sep) ? (job_ff.step - rd_ff.last_sep) : '0;
      sum_wide = {1'b0, rd_ff.sum} + (SW+1)'(add);
      upd      = rd_ff;
      if (job_ff.contact && !rd_ff.flag) begin
         upd.sum   = sum_wide[SW] ? pftt_pkg::SUM_MAX : sum_wide[SW-1:0];
         upd.count = (rd_ff.count == pftt_pkg::CNT_MAX) ? rd_ff.count
                                                        : rd_ff.count + 1'b1;
         upd.flag  = 1'b1;
      end else if (!job_ff.contact && rd_ff.flag) begin
         upd.last_sep = job_ff.step;
         upd.flag     = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pftt_pkg::ST_CLEAR;
         clr_ptr_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == pftt_pkg::ST_CLEAR) begin
            clr_ptr_ff <= clr_ptr_ff + AW'(1);
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // particle table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_ff[mem_addr] <= mem_wdata;
      end
      if (job_pop) begin
         rd_ff <= table_ff[job_head.idx[AW-1:0]];
      end
   end

   // job capture and result register
   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_head;
      end
      if (load_out) begin
         rsp_out_particle    <= job_ff.idx;
         rsp_free_time_total <= upd.sum;
         rsp_collisions      <= upd.count;
         rsp_touching        <= upd.flag;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

FILE: rtl/particle_free_time_tracker.sv
// channel   | handshake      | payload
// ----------+----------------+--------------------------------------------------
// request   | push / full    | req_particle_index .. req_last_neighbor, one pair
// response  | pop / empty    | rsp_out_particle, rsp_free_time_total,
//           |                | rsp_collisions, rsp_touching, one per tracked, started, in-range last pair
// csr       | csr_wr_en      | csr_wr_data = start_step
//
// a pair enters a three stage contact pipeline (abs diff, square, sum) one per cycle
// unless full is high; each last pair then takes a registered read and a write in the
// particle table; after reset the table is swept one entry a cycle over min(PARTICLES,
// 4096) entries (4096 by default), with full held high; full also rises when the
// 4-entry job queue is full and a last pair waits at the pipeline end; a result not
// popped holds the back end
module particle_free_time_tracker #(
   parameter int PARTICLES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [pftt_pkg::STEP_W-1:0]         csr_wr_data,
   input  logic                                push,
   output logic                                full,
   input  logic [pftt_pkg::IDX_W-1:0]          req_particle_index,
   input  logic                                req_in_group,
   input  logic [pftt_pkg::STEP_W-1:0]         req_step,
   input  logic signed [pftt_pkg::POS_W-1:0]   req_own_x,
   input  logic signed [pftt_pkg::POS_W-1:0]   req_own_y,
   input  logic signed [pftt_pkg::POS_W-1:0]   req_own_z,
   input  logic [pftt_pkg::RAD_W-1:0]          req_own_radius,
   input  logic signed [pftt_pkg::POS_W-1:0]   req_other_x,
   input  logic signed [pftt_pkg::POS_W-1:0]   req_other_y,
   input  logic signed [pftt_pkg::POS_W-1:0]   req_other_z,
   input  logic [pftt_pkg::RAD_W-1:0]          req_other_radius,
   input  logic                                req_last_neighbor,
   output logic                                empty,
   input  logic                                pop,
   output logic [pftt_pkg::IDX_W-1:0]          rsp_out_particle,
   output logic [pftt_pkg::SUM_W-1:0]          rsp_free_time_total,
   output logic [pftt_pkg::CNT_W-1:0]          rsp_collisions,
   output logic                                rsp_touching
);

   logic [pftt_pkg::STEP_W-1:0] start_step_ff;
   logic                        front_ready;
   logic                        clearing;
   logic                        accepted;
   logic                        job_push;
   logic                        job_full;
   logic                        job_empty;
   logic                        job_pop;
   pftt_pkg::job_type           job_in;
   pftt_pkg::job_type           job_head;
   logic                        rsp_valid;

   // start step register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_step_ff <= '0;
      end else if (csr_wr_en) begin
         start_step_ff <= csr_wr_data;
      end
   end

   // request handshake
   assign full     = !front_ready || clearing;
   assign accepted = push && !full;

   pftt_front #(
      .PARTICLES (PARTICLES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start_step        (start_step_ff),
      .in_valid          (accepted),
      .in_ready          (front_ready),
      .in_particle_index (req_particle_index),
      .in_in_group       (req_in_group),
      .in_step           (req_step),
      .in_own_x          (req_own_x),
      .in_own_y          (req_own_y),
      .in_own_z          (req_own_z),
      .in_own_radius     (req_own_radius),
      .in_other_x        (req_other_x),
      .in_other_y        (req_other_y),
      .in_other_z        (req_other_z),
      .in_other_radius   (req_other_radius),
      .in_last_neighbor  (req_last_neighbor),
      .job_push          (job_push),
      .job               (job_in),
      .job_full          (job_full)
   );

   pftt_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job_in),
      .full    (job_full),
      .rd_en   (job_pop),
      .rd_data (job_head),
      .empty   (job_empty)
   );

   pftt_back #(
      .PARTICLES (PARTICLES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .job_empty           (job_empty),
      .job_head            (job_head),
      .job_pop             (job_pop),
      .clearing            (clearing),
      .rsp_valid           (rsp_valid),
      .rsp_take            (pop && rsp_valid),
      .rsp_out_particle    (rsp_out_particle),
      .rsp_free_time_total (rsp_free_time_total),
      .rsp_collisions      (rsp_collisions),
      .rsp_touching        (rsp_touching)
   );

   // response handshake
   assign empty = !rsp_valid;

endmodule

FILE: rtl/pftt_checker.sv
module pftt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                full,
   input logic                                empty,
   input logic                                pop,
   input logic [pftt_pkg::IDX_W-1:0]          rsp_out_particle,
   input logic [pftt_pkg::SUM_W-1:0]          rsp_free_time_total,
   input logic [pftt_pkg::CNT_W-1:0]          rsp_collisions,
   input logic                                rsp_touching
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> empty)
      else $error("result shown right after reset");

   // table sweep blocks requests right after reset
   assert property (@(posedge clock) reset |=> full)
      else $error("request side open during table sweep");

   // free time only builds up at a counted collision
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_free_time_total != '0) |-> (rsp_collisions != '0))
      else $error("free time without any collision");

   // a waiting result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_particle)
                            && $stable(rsp_free_time_total)
                            && $stable(rsp_collisions) && $stable(rsp_touching)))
      else $error("waiting result changed or dropped");

endmodule

bind particle_free_time_tracker pftt_checker u_pftt_checker (.*);
